[rtl/lrsh_pkg.sv]
// ----------------------------------------------------------------------------
// lrsh_pkg
// Shared types, constants and the fp32 to fp16 packing function of the
// linear RGBA scale-to-half block.
// ----------------------------------------------------------------------------
package lrsh_pkg;

  typedef struct packed {
    logic [31:0] red_in;
    logic [31:0] green_in;
    logic [31:0] blue_in;
    logic [31:0] alpha_in;
  } in_pix_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] alpha_out;
  } out_pix_t;

  typedef enum logic [1:0] {
    CFG_GAIN      = 2'd0,
    CFG_MAX_LEVEL = 2'd1,
    CFG_COMPOSITE = 2'd2
  } cfg_idx_t;

  localparam logic [31:0] FP32_ONE       = 32'h3f80_0000;
  localparam logic [31:0] FP32_QNAN      = 32'h7fc0_0000;
  localparam logic [31:0] GAIN_RST       = 32'h3f80_0000;
  localparam logic [31:0] MAX_LEVEL_RST  = 32'h4780_0000;
  localparam logic [14:0] HALF_QNAN      = 15'h7e00;
  localparam logic [14:0] HALF_INF       = 15'h7c00;
  localparam int          LAT            = 8;

  // fp32 to fp16: truncate, round half up on the guard bit, flush tiny
  // values to signed zero, overflow to infinity or quiet NaN.
  function automatic logic [15:0] pack_half(input logic [31:0] x);
    logic              sgn;
    logic signed [9:0] e;
    logic [23:0]       frac;
    logic [4:0]        sh;
    logic [10:0]       m;
    logic [15:0]       h;
    sgn  = x[31];
    e    = $signed({2'b00, x[30:23]}) - 10'sd112;
    frac = {1'b0, x[22:0]};
    sh   = 5'd0;
    m    = 11'd0;
    h    = 16'd0;
    if (e < -10'sd10) begin
      h = {sgn, 15'd0};
    end else if (e <= 10'sd0) begin
      frac[23] = 1'b1;
      sh = 5'd14 - e[4:0];
      m  = 11'(frac >> sh);
      if (frac[sh - 5'd1]) begin
        m = m + 11'd1;
      end
      h = {sgn, 4'd0, m};
    end else if (e >= 10'sd31) begin
      h = (frac != 24'd0) ? {sgn, HALF_QNAN} : {sgn, HALF_INF};
    end else begin
      h = {sgn, e[4:0], x[22:13]} + {15'd0, x[12]};
    end
    return h;
  endfunction

endpackage

[rtl/lrsh_fmul.sv]
// ----------------------------------------------------------------------------
// lrsh_fmul
// Three-stage IEEE-754 single precision multiplier, round to nearest even,
// with subnormal inputs and outputs. Stage 1 multiplies the significands,
// stage 2 normalizes, stage 3 denormalizes, rounds and packs.
// ----------------------------------------------------------------------------
module lrsh_fmul (
  input  logic        clk,
  input  logic [31:0] a_in,
  input  logic [31:0] b_in,
  output logic [31:0] y_out
);

  // stage 1
  logic [7:0]         ea, eb;
  logic               a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
  logic               sign1_r, nan1_r, inf1_r, zero1_r;
  logic [47:0]        prod1_r;
  logic signed [10:0] exp1_r;

  assign ea     = a_in[30:23];
  assign eb     = b_in[30:23];
  assign a_zero = (ea == 8'h00) && (a_in[22:0] == 23'd0);
  assign b_zero = (eb == 8'h00) && (b_in[22:0] == 23'd0);
  assign a_inf  = (ea == 8'hff) && (a_in[22:0] == 23'd0);
  assign b_inf  = (eb == 8'hff) && (b_in[22:0] == 23'd0);
  assign a_nan  = (ea == 8'hff) && (a_in[22:0] != 23'd0);
  assign b_nan  = (eb == 8'hff) && (b_in[22:0] != 23'd0);

  always_ff @(posedge clk) begin
    sign1_r <= a_in[31] ^ b_in[31];
    nan1_r  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    inf1_r  <= a_inf | b_inf;
    zero1_r <= a_zero | b_zero;
    prod1_r <= {(ea != 8'h00), a_in[22:0]} * {(eb != 8'h00), b_in[22:0]};
    exp1_r  <= $signed({3'b000, (ea == 8'h00) ? 8'd1 : ea})
             + $signed({3'b000, (eb == 8'h00) ? 8'd1 : eb}) - 11'sd126;
  end

  // stage 2: leading-one search and normalize
  logic [5:0]         lz;
  logic               found;
  logic               sign2_r, nan2_r, inf2_r, zero2_r;
  logic [47:0]        norm2_r;
  logic signed [10:0] exp2_r;

  always_comb begin
    lz    = 6'd0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && prod1_r[i]) begin
        lz    = 6'(47 - i);
        found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sign2_r <= sign1_r;
    nan2_r  <= nan1_r;
    inf2_r  <= inf1_r;
    zero2_r <= zero1_r;
    norm2_r <= prod1_r << lz;
    exp2_r  <= exp1_r - $signed({5'd0, lz});
  end

  // stage 3: denormalize, round, pack
  localparam logic [31:0] FP32_QNAN_L = lrsh_pkg::FP32_QNAN;

  logic signed [10:0] sh_full;
  logic [5:0]         sh;
  logic [71:0]        ext;
  logic               guard, sticky, rnd, ovf;
  logic [7:0]         expf;
  logic [31:0]        sum;
  logic [31:0]        y_nxt;

  always_comb begin
    sh_full = 11'sd1 - exp2_r;
    if (exp2_r >= 11'sd1) begin
      sh = 6'd0;
    end else if (sh_full > 11'sd50) begin
      sh = 6'd50;
    end else begin
      sh = sh_full[5:0];
    end
    ext    = {norm2_r, 24'd0} >> sh;
    guard  = ext[47];
    sticky = |ext[46:0];
    rnd    = guard & (sticky | ext[48]);
    expf   = (exp2_r >= 11'sd1) ? exp2_r[7:0] : 8'd0;
    sum    = {1'b0, expf, ext[70:48]} + {31'd0, rnd};
    ovf    = (exp2_r >= 11'sd255) || (sum[30:23] == 8'hff);
    if (nan2_r) begin
      y_nxt = FP32_QNAN_L;
    end else if (inf2_r || (!zero2_r && ovf)) begin
      y_nxt = {sign2_r, 8'hff, 23'd0};
    end else if (zero2_r) begin
      y_nxt = {sign2_r, 31'd0};
    end else begin
      y_nxt = {sign2_r, sum[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    y_out <= y_nxt;
  end

endmodule

[rtl/lrsh_lane.sv]
// ----------------------------------------------------------------------------
// lrsh_lane
// One colour lane: scale by gain, multiply by the alpha factor, then drop
// non-finite or negative values and clamp to the upper level.
// ----------------------------------------------------------------------------
module lrsh_lane (
  input  logic        clk,
  input  logic [31:0] x_in,
  input  logic [31:0] gain,
  input  logic [31:0] amul,
  input  logic [31:0] top,
  output logic [31:0] y_out
);

  logic [31:0] scaled, mixed;
  logic [31:0] y_nxt;
  logic        bad, top_nan, above;

  lrsh_fmul u_gain (.clk(clk), .a_in(x_in),   .b_in(gain), .y_out(scaled));
  lrsh_fmul u_amul (.clk(clk), .a_in(scaled), .b_in(amul), .y_out(mixed));

  always_comb begin
    bad     = (mixed[30:23] == 8'hff) || (mixed[31] && (mixed[30:0] != 31'd0));
    top_nan = (top[30:23] == 8'hff) && (top[22:0] != 23'd0);
    // value is +0, -0 or positive finite here
    if (top_nan) begin
      above = 1'b0;
    end else if (top[31]) begin
      above = (mixed[30:0] != 31'd0) || (top[30:0] != 31'd0);
    end else begin
      above = mixed[30:0] > top[30:0];
    end
    if (bad) begin
      y_nxt = 32'd0;
    end else if (above) begin
      y_nxt = top;
    end else begin
      y_nxt = mixed;
    end
  end

  always_ff @(posedge clk) begin
    y_out <= y_nxt;
  end

endmodule

[rtl/linear_rgba_scale_to_half_core.sv]
// ----------------------------------------------------------------------------
// linear_rgba_scale_to_half_core
// Scales, premultiplies, clamps and packs one fp32 RGBA pixel to fp16.
// ----------------------------------------------------------------------------
// A pixel is taken on every cycle that start is high; busy stays low. Each
// request returns its result on out_data with out_valid high for exactly one
// cycle, in request order. The datapath has eight register stages: two
// three-stage fp32 multipliers in series per colour lane (gain, then alpha),
// a clamp stage and the fp16 pack/output register. The receiver cannot stall:
// results must be taken when out_valid is high.
// ----------------------------------------------------------------------------
module linear_rgba_scale_to_half_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lrsh_pkg::in_pix_t  in_data,
  output logic               out_valid,
  output lrsh_pkg::out_pix_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata
);

  localparam int LAT = lrsh_pkg::LAT;

  logic [31:0] gain_r, max_level_r;
  logic        comp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= lrsh_pkg::GAIN_RST;
      max_level_r <= lrsh_pkg::MAX_LEVEL_RST;
      comp_r      <= 1'b1;
    end else if (cfg_we) begin
      case (lrsh_pkg::cfg_idx_t'(cfg_addr))
        lrsh_pkg::CFG_GAIN:      gain_r      <= cfg_wdata;
        lrsh_pkg::CFG_MAX_LEVEL: max_level_r <= cfg_wdata;
        lrsh_pkg::CFG_COMPOSITE: comp_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // alpha clamp and composite decision
  logic [31:0] a_in, a_c, amul, afin;
  logic        premul;

  always_comb begin
    a_in = in_data.alpha_in;
    if ((a_in[30:23] == 8'hff) || (a_in[31] && (a_in[30:0] != 31'd0))) begin
      a_c = 32'd0;
    end else if (!a_in[31] && (a_in[30:0] > lrsh_pkg::FP32_ONE[30:0])) begin
      a_c = lrsh_pkg::FP32_ONE;
    end else begin
      a_c = a_in;
    end
    premul = comp_r && (a_c != lrsh_pkg::FP32_ONE);
    amul   = premul ? a_c : lrsh_pkg::FP32_ONE;
    afin   = premul ? lrsh_pkg::FP32_ONE : a_c;
  end

  logic [2:0][31:0]     amul_r;
  logic [LAT-2:0][31:0] afin_r;
  logic [LAT-1:0]       vld_r;

  always_ff @(posedge clk) begin
    amul_r <= {amul_r[1:0], amul};
    afin_r <= {afin_r[LAT-3:0], afin};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  logic [31:0] r_c, g_c, b_c;

  lrsh_lane u_red (
    .clk(clk), .x_in(in_data.red_in), .gain(gain_r), .amul(amul_r[2]),
    .top(max_level_r), .y_out(r_c)
  );
  lrsh_lane u_green (
    .clk(clk), .x_in(in_data.green_in), .gain(gain_r), .amul(amul_r[2]),
    .top(max_level_r), .y_out(g_c)
  );
  lrsh_lane u_blue (
    .clk(clk), .x_in(in_data.blue_in), .gain(gain_r), .amul(amul_r[2]),
    .top(max_level_r), .y_out(b_c)
  );

  // merge lanes and pack to half
  lrsh_pkg::out_pix_t out_nxt;

  always_comb begin
    out_nxt.red_out   = lrsh_pkg::pack_half(r_c);
    out_nxt.green_out = lrsh_pkg::pack_half(g_c);
    out_nxt.blue_out  = lrsh_pkg::pack_half(b_c);
    out_nxt.alpha_out = lrsh_pkg::pack_half(afin_r[LAT-2]);
  end

  always_ff @(posedge clk) begin
    out_data <= out_nxt;
  end

  assign out_valid = vld_r[LAT-1];

  a_lat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without request");

  a_alpha_nan : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.alpha_out[14:10] != 5'h1f))
    else $error("alpha output not finite");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for linear_rgba_scale_to_half_core: drives fp32 RGBA
// requests through directed and random phases under several register settings
// and compares each fp16 result against a bit-exact software predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  lrsh_pkg::in_pix_t    in_data = '0;
  logic                 out_valid;
  lrsh_pkg::out_pix_t   out_data;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_addr = lrsh_pkg::CFG_GAIN;
  logic [31:0]          cfg_wdata = '0;

  logic [31:0]          gain_reg;
  logic [31:0]          max_level_reg;
  logic                 composite_reg;
  lrsh_pkg::out_pix_t   expected_pixels[$];
  int                   error_count = 0;
  int                   idle_pct = 0;

  localparam logic [31:0] FP_PINF = 32'h7f80_0000;
  localparam logic [31:0] FP_NINF = 32'hff80_0000;
  localparam logic [31:0] FP_NZERO = 32'h8000_0000;
  localparam logic [31:0] FP_MAXN = 32'h7f7f_ffff;

  linear_rgba_scale_to_half_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic bit is_nan(logic [31:0] x);
    return x[30:23] == 8'hff && x[22:0] != 23'd0;
  endfunction

  // ordering key for non-NaN values; both zeros map to 0
  function automatic longint order_key(logic [31:0] x);
    if (x[30:0] == 31'd0) return 0;
    return x[31] ? -longint'(x[30:0]) : longint'(x[30:0]);
  endfunction

  function automatic bit fp_gt(logic [31:0] a, logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    return order_key(a) > order_key(b);
  endfunction

  // single precision multiply, round to nearest even
  function automatic logic [31:0] fp32_mul(logic [31:0] a, logic [31:0] b);
    logic        sgn;
    logic [63:0] ma, mb, p, m, rem, half, r;
    int          ea, eb, msb, s, e_res;
    bit          inf_a, inf_b, zero_a, zero_b;
    sgn = a[31] ^ b[31];
    inf_a = a[30:0] == FP_PINF[30:0];
    inf_b = b[30:0] == FP_PINF[30:0];
    zero_a = a[30:0] == 31'd0;
    zero_b = b[30:0] == 31'd0;
    if (is_nan(a) || is_nan(b) || (inf_a && zero_b) || (inf_b && zero_a))
      return lrsh_pkg::FP32_QNAN;
    if (inf_a || inf_b) return {sgn, FP_PINF[30:0]};
    if (zero_a || zero_b) return {sgn, 31'd0};
    ma = (a[30:23] == 8'd0) ? {41'd0, a[22:0]} : {40'd0, 1'b1, a[22:0]};
    mb = (b[30:23] == 8'd0) ? {41'd0, b[22:0]} : {40'd0, 1'b1, b[22:0]};
    ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
    eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
    p = ma * mb;
    msb = 0;
    for (int i = 0; i < 48; i++) if (p[i]) msb = i;
    e_res = msb + ea + eb - 173;
    s = msb - 23;
    if (e_res < 1) begin
      s = s + 1 - e_res;
      e_res = 0;
    end
    if (e_res >= 255) return {sgn, FP_PINF[30:0]};
    if (s <= 0) begin
      m = p << (-s);
    end else begin
      if (s > 50) s = 50;
      m = p >> s;
      rem = p & ((64'd1 << s) - 64'd1);
      half = 64'd1 << (s - 1);
      if (rem > half || (rem == half && m[0])) m = m + 64'd1;
    end
    // hidden bit carries into the exponent field
    r = (e_res == 0) ? m : ((64'(e_res - 1) << 23) + m);
    if (r >= 64'(FP_PINF)) return {sgn, FP_PINF[30:0]};
    return {sgn, r[30:0]};
  endfunction

  function automatic logic [15:0] to_half(logic [31:0] x);
    logic [31:0] sgn16, f, m, h;
    int          e, sh;
    sgn16 = {16'd0, x[31], 15'd0};
    e = int'(x[30:23]) - 112;
    if (e < -10) return sgn16[15:0];
    if (e <= 0) begin
      f = {8'd0, 1'b1, x[22:0]};
      sh = 14 - e;
      m = f >> sh;
      if (f[sh - 1]) m = m + 32'd1;
      return sgn16[15:0] | m[15:0];
    end
    if (e >= 31)
      return (x[22:0] != 23'd0) ? {x[31], lrsh_pkg::HALF_QNAN}
                                : {x[31], lrsh_pkg::HALF_INF};
    h = sgn16 | (32'(e) << 10) | {19'd0, x[22:10] >> 3};
    if (x[12]) h = h + 32'd1;
    return h[15:0];
  endfunction

  function automatic logic [31:0] clamp_level(logic [31:0] v);
    if (v[30:23] == 8'hff || fp_gt(32'd0, v)) return 32'd0;
    if (fp_gt(v, max_level_reg)) return max_level_reg;
    return v;
  endfunction

  function automatic lrsh_pkg::out_pix_t scale_pack_pixel(lrsh_pkg::in_pix_t px);
    logic [31:0]        r, g, b, a;
    lrsh_pkg::out_pix_t res;
    r = fp32_mul(px.red_in, gain_reg);
    g = fp32_mul(px.green_in, gain_reg);
    b = fp32_mul(px.blue_in, gain_reg);
    a = px.alpha_in;
    if (a[30:23] == 8'hff || fp_gt(32'd0, a)) a = 32'd0;
    if (fp_gt(a, lrsh_pkg::FP32_ONE)) a = lrsh_pkg::FP32_ONE;
    if (composite_reg && fp_gt(lrsh_pkg::FP32_ONE, a)) begin
      r = fp32_mul(r, a);
      g = fp32_mul(g, a);
      b = fp32_mul(b, a);
      a = lrsh_pkg::FP32_ONE;
    end
    res.red_out = to_half(clamp_level(r));
    res.green_out = to_half(clamp_level(g));
    res.blue_out = to_half(clamp_level(b));
    res.alpha_out = to_half(a);
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    lrsh_pkg::out_pix_t want;
    if (rst_n && out_valid) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result exp none act %h", $time, out_data);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (want.red_out !== out_data.red_out)
          $display("%0t: red exp %h act %h", $time, want.red_out, out_data.red_out);
        if (want.green_out !== out_data.green_out)
          $display("%0t: green exp %h act %h", $time, want.green_out, out_data.green_out);
        if (want.blue_out !== out_data.blue_out)
          $display("%0t: blue exp %h act %h", $time, want.blue_out, out_data.blue_out);
        if (want.alpha_out !== out_data.alpha_out)
          $display("%0t: alpha exp %h act %h", $time, want.alpha_out, out_data.alpha_out);
        if (want !== out_data) error_count++;
      end
    end
  end

  task automatic send_pixel(lrsh_pkg::in_pix_t px);
    // idle the given share of cycles before the request
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_data <= px;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_pixels.push_back(scale_pack_pixel(px));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (lrsh_pkg::LAT + 2) @(posedge clk);
  endtask

  task automatic write_reg(lrsh_pkg::cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lrsh_pkg::CFG_GAIN:      gain_reg = val;
      lrsh_pkg::CFG_MAX_LEVEL: max_level_reg = val;
      default:                 composite_reg = val[0];
    endcase
  endtask

  function automatic logic [31:0] rand_fp();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0, 1, 2: ;
      3: v[30:23] = 8'($urandom_range(100, 145));
      4: v = {1'b0, 8'($urandom_range(112, 128)), v[22:0]};
      5: v = {1'b0, 8'($urandom_range(100, 126)), v[22:0]};
      6: v[30:23] = 8'd0;
      7: v = {v[31], 8'($urandom_range(141, 143)), v[22:0]};
      8: case ($urandom_range(5))
           0: v = FP_PINF;  1: v = FP_NINF;  2: v = FP_NZERO;
           3: v = 32'd0;    4: v = {v[31], 8'hff, v[22:0] | 23'd1};
           default: v = lrsh_pkg::FP32_ONE;
         endcase
      default: v = {1'b0, 8'($urandom_range(120, 127)), v[22:0]};
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_alpha();
    if ($urandom_range(2) == 0) return rand_fp();
    return {1'b0, 8'($urandom_range(110, 127)), 23'($urandom)};
  endfunction

  task automatic test_directed();
    logic [31:0] edge_vals[14];
    edge_vals = '{32'd0, FP_NZERO, FP_PINF, FP_NINF, lrsh_pkg::FP32_QNAN, 32'hffff_ffff,
                  FP_MAXN, 32'h0000_0001, 32'h477f_f000, 32'h477f_e000, 32'h3880_0000,
                  32'h3300_0000, 32'h3f80_0001, 32'hbf00_0000};
    for (int i = 0; i < 14; i++)
      send_pixel('{edge_vals[i], edge_vals[(i + 3) % 14], edge_vals[(i + 7) % 14],
                   edge_vals[(i + 5) % 14]});
    send_pixel('{32'h4000_0000, 32'h3f00_0000, 32'h477f_ffff, lrsh_pkg::FP32_ONE});
    send_pixel('{32'h4000_0000, 32'h3f00_0000, 32'h477f_ffff, FP_NZERO});
    send_pixel('{32'h4000_0000, 32'h3f00_0000, 32'h477f_ffff, 32'h3f00_0000});
    send_pixel('{32'h4000_0000, 32'h3f00_0000, 32'h477f_ffff, 32'h4000_0000});
    send_pixel('{32'h387f_e000, 32'h3380_0000, 32'h3370_0000, lrsh_pkg::FP32_QNAN});
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_pixel('{rand_fp(), rand_fp(), rand_fp(), rand_alpha()});
  endtask

  task automatic test_setting(logic [31:0] g, logic [31:0] ml, logic comp, int n);
    drain_results();
    write_reg(lrsh_pkg::CFG_GAIN, g);
    write_reg(lrsh_pkg::CFG_MAX_LEVEL, ml);
    write_reg(lrsh_pkg::CFG_COMPOSITE, {31'd0, comp});
    test_random(n);
  endtask

  initial begin
    gain_reg = lrsh_pkg::GAIN_RST;
    max_level_reg = lrsh_pkg::MAX_LEVEL_RST;
    composite_reg = 1'b1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 24;
    test_directed();
    test_random(150);
    test_setting(lrsh_pkg::GAIN_RST, lrsh_pkg::MAX_LEVEL_RST, 1'b0, 0);
    test_directed();
    test_setting(32'h4080_0000, 32'h477f_e000, 1'b0, 150);
    test_setting(32'd0, lrsh_pkg::FP32_QNAN, 1'b1, 100);
    idle_pct = 84;
    test_setting(FP_PINF, 32'hbf80_0000, 1'b0, 100);
    test_setting(32'hffff_ffff, FP_MAXN, 1'b1, 100);
    test_setting(32'h0000_0001, 32'd0, 1'b0, 100);
    test_setting(FP_MAXN, FP_PINF, 1'b1, 150);
    idle_pct = 0;
    test_setting(32'h3e80_0000, 32'h4780_0000, 1'b1, 200);
    test_setting(32'hc000_0000, 32'h3f80_0000, 1'b0, 150);
    test_setting(32'h7fff_ffff, 32'hffff_ffff, 1'b0, 100);
    test_setting(32'h3f7f_ffff, 32'h4000_0000, 1'b1, 200);
    test_setting(32'($urandom), 32'($urandom), 1'($urandom), 150);
    drain_results();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
